// File: design/yrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_pkg
// Shared widths, register indexes and BT.601 coefficients for the YUYV to
// RGB blend unit.
// ----------------------------------------------------------------------------
package yrb_pkg;

    localparam int unsigned SampleW  = 8;
    localparam int unsigned PixelW   = 24;
    localparam int unsigned InDataW  = 80;
    localparam int unsigned OutDataW = 48;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 8;
    localparam int unsigned AccW     = 28;

    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GAMMA_OFFSET = 2'd0;
    localparam t_cfg_idx CFG_BLUR_ENABLE  = 2'd1;
    localparam t_cfg_idx CFG_MONO_ENABLE  = 2'd2;

    localparam logic signed [AccW-1:0] COEF_Y     = 28'sd76283;
    localparam logic signed [AccW-1:0] COEF_R_CR  = 28'sd104595;
    localparam logic signed [AccW-1:0] COEF_G_CR  = 28'sd53281;
    localparam logic signed [AccW-1:0] COEF_G_CB  = 28'sd25624;
    localparam logic signed [AccW-1:0] COEF_B_CB  = 28'sd132252;
    localparam logic signed [AccW-1:0] LUMA_BIAS  = 28'sd16;
    localparam logic signed [AccW-1:0] CHROMA_BIAS = 28'sd128;
    localparam logic [PixelW-1:0]      HALF_MASK  = 24'h7f7f7f;

    typedef struct packed {
        logic [SampleW-1:0] gamma_offset;
        logic               blur_enable;
        logic               mono_enable;
    } t_cfg;

    // floor(x / 2^16) clamped to 0..255
    function automatic logic [SampleW-1:0] clamp_channel(
        input logic signed [AccW-1:0] x
    );
        logic [SampleW-1:0] res;
        if (x[AccW-1]) begin
            res = '0;
        end else if (|x[AccW-2:24]) begin
            res = '1;
        end else begin
            res = x[23:16];
        end
        return res;
    endfunction

endpackage

// File: design/yuyv_to_rgb_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuyv_to_rgb_blend_unit
// 4:2:2 YUYV pair to two packed RGB888 pixels with grey mode and blur.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock while the output is not stalled and
// returns one result beat per input beat through an input register,
// one pass of conversion logic (one constant multiply per term, then
// add and clamp), and an output register. Sustained rate is one pair per
// cycle, limited only by the output side's tready. Configuration writes
// take effect on beats that reach the conversion stage afterwards; write
// them while no beat is in flight.
module yuyv_to_rgb_blend_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  yrb_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [yrb_pkg::CfgDataW-1:0]      i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // luma_first, chroma_red, luma_second, chroma_blue,
    // old_pixel_first, old_pixel_second
    input  logic [yrb_pkg::InDataW-1:0]       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // rgb_first, rgb_second
    output logic [yrb_pkg::OutDataW-1:0]      m_axis_tdata
);
    import yrb_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_in_valid;
    logic [InDataW-1:0]     r_in_data;
    logic                   r_out_valid;
    logic [OutDataW-1:0]    r_out_data;
    logic                   out_adv;
    logic                   in_acc;
    logic [PixelW-1:0]      rgb_first, rgb_second;

    assign out_adv       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || out_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAMMA_OFFSET: r_cfg.gamma_offset <= i_cfg_data;
                CFG_BLUR_ENABLE:  r_cfg.blur_enable  <= i_cfg_data[0];
                CFG_MONO_ENABLE:  r_cfg.mono_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_data <= s_axis_tdata;
        end
    end

    yrb_pixel u_pix_first (
        .i_cfg  (r_cfg),
        .i_luma (r_in_data[7:0]),
        .i_cr   (r_in_data[15:8]),
        .i_cb   (r_in_data[31:24]),
        .i_old  (r_in_data[55:32]),
        .o_rgb  (rgb_first)
    );

    yrb_pixel u_pix_second (
        .i_cfg  (r_cfg),
        .i_luma (r_in_data[23:16]),
        .i_cr   (r_in_data[15:8]),
        .i_cb   (r_in_data[31:24]),
        .i_old  (r_in_data[79:56]),
        .o_rgb  (rgb_second)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_in_valid) begin
            r_out_data <= {rgb_second, rgb_first};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: design/yrb_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_pixel
// One pixel: gamma offset, BT.601 or grey conversion, optional half-sum
// blend with the stored pixel.
// ----------------------------------------------------------------------------
module yrb_pixel (
    input  yrb_pkg::t_cfg                    i_cfg,
    input  logic [yrb_pkg::SampleW-1:0]      i_luma,
    input  logic [yrb_pkg::SampleW-1:0]      i_cr,
    input  logic [yrb_pkg::SampleW-1:0]      i_cb,
    input  logic [yrb_pkg::PixelW-1:0]       i_old,
    output logic [yrb_pkg::PixelW-1:0]       o_rgb
);
    import yrb_pkg::*;

    logic [SampleW-1:0]         y_adj;
    logic signed [AccW-1:0]     yy, vv, uu;
    logic signed [AccW-1:0]     y_term;
    logic signed [AccW-1:0]     r_sum, g_sum, b_sum;
    logic [PixelW-1:0]          new_px;

    assign y_adj = i_luma + i_cfg.gamma_offset;

    assign yy = signed'(AccW'(y_adj)) - LUMA_BIAS;
    assign vv = signed'(AccW'(i_cr)) - CHROMA_BIAS;
    assign uu = signed'(AccW'(i_cb)) - CHROMA_BIAS;

    assign y_term = COEF_Y * yy;
    assign r_sum  = y_term + COEF_R_CR * vv;
    assign g_sum  = y_term - COEF_G_CR * vv - COEF_G_CB * uu;
    assign b_sum  = y_term + COEF_B_CB * uu;

    always_comb begin
        if (i_cfg.mono_enable) begin
            new_px = {y_adj, y_adj, y_adj};
        end else begin
            new_px = {clamp_channel(b_sum), clamp_channel(g_sum), clamp_channel(r_sum)};
        end
    end

    always_comb begin
        if (i_cfg.blur_enable) begin
            o_rgb = (HALF_MASK & (i_old >> 1)) + (HALF_MASK & (new_px >> 1));
        end else begin
            o_rgb = new_px;
        end
    end

endmodule

// File: design/yrb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yrb_checker
// Port-level checks for the YUYV to RGB blend unit, bound to the top level.
// ----------------------------------------------------------------------------
module yrb_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [yrb_pkg::OutDataW-1:0]      m_axis_tdata
);
    import yrb_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output beat changed");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output free");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result beat missing two cycles after input");

endmodule

bind yuyv_to_rgb_blend_unit yrb_checker u_yrb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata)
);

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the YUYV to RGB blend unit. A short stimulus table
// covers luma and chroma extremes, gamma wrap, grey mode, blur, an unused
// register index and oversized register data. Random pairs follow under
// changing register settings and back-pressure phases. Every output beat
// is compared against its table value or an in-bench BT.601 fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    import yrb_pkg::*;

    localparam int  ClkHalf    = 5;
    localparam int  WatchLimit = 5000;
    localparam int  DrainWait  = 4;
    localparam int  SegItems   = 100;
    localparam int  Segments   = 8;

    localparam t_cfg_idx CFG_SPARE = 2'd3;

    localparam int  Y_GAIN    = 76283;
    localparam int  R_CR_GAIN = 104595;
    localparam int  G_CR_GAIN = 53281;
    localparam int  G_CB_GAIN = 25624;
    localparam int  B_CB_GAIN = 132252;
    localparam int  Y_OFFSET  = 16;
    localparam int  C_OFFSET  = 128;
    localparam logic [PixelW-1:0] HALF_BITS = 24'h7f7f7f;

    typedef enum logic {ROW_WRITE, ROW_PAIR} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [CfgDataW-1:0]   val;
        logic [InDataW-1:0]    pair;
        bit                    known;
        logic [OutDataW-1:0]   rgb;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_index = '0;
    logic [CfgDataW-1:0]   i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InDataW-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   m_axis_tdata;

    t_cfg                  cfg_now = '0;
    logic [OutDataW-1:0]   rgb_expect_q[$];
    t_stim_row             stim_rows[$];
    int                    mismatch_count = 0;
    int                    idle_pct = 0;
    int                    stall_pct = 0;
    int                    quiet_cycles = 0;

    yuyv_to_rgb_blend_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #ClkHalf i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic logic [SampleW-1:0] clamp_to_byte(input int acc);
        int q;
        q = acc >>> 16;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic logic [PixelW-1:0] pixel_from_yuv(
        input logic [SampleW-1:0] y,
        input logic [SampleW-1:0] cr,
        input logic [SampleW-1:0] cb,
        input logic               mono
    );
        int yy, vv, uu;
        logic [SampleW-1:0] r, g, b;
        yy = int'(y) - Y_OFFSET;
        vv = int'(cr) - C_OFFSET;
        uu = int'(cb) - C_OFFSET;
        if (mono) return {y, y, y};
        r = clamp_to_byte(Y_GAIN * yy + R_CR_GAIN * vv);
        g = clamp_to_byte(Y_GAIN * yy - G_CR_GAIN * vv - G_CB_GAIN * uu);
        b = clamp_to_byte(Y_GAIN * yy + B_CB_GAIN * uu);
        return {b, g, r};
    endfunction

    function automatic logic [PixelW-1:0] blend_with_stored(
        input logic [PixelW-1:0] stored,
        input logic [PixelW-1:0] fresh,
        input logic              blur
    );
        if (!blur) return fresh;
        return (HALF_BITS & (stored >> 1)) + (HALF_BITS & (fresh >> 1));
    endfunction

    function automatic logic [OutDataW-1:0] predict_rgb_pair(
        input logic [InDataW-1:0] d,
        input t_cfg               c
    );
        logic [SampleW-1:0] y1, y2;
        logic [PixelW-1:0]  p1, p2;
        y1 = d[7:0] + c.gamma_offset;
        y2 = d[23:16] + c.gamma_offset;
        p1 = blend_with_stored(d[55:32],
                pixel_from_yuv(y1, d[15:8], d[31:24], c.mono_enable), c.blur_enable);
        p2 = blend_with_stored(d[79:56],
                pixel_from_yuv(y2, d[15:8], d[31:24], c.mono_enable), c.blur_enable);
        return {p2, p1};
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [InDataW-1:0] pack_pair(
        input logic [7:0] y1, input logic [7:0] cr,
        input logic [7:0] y2, input logic [7:0] cb,
        input logic [23:0] o1, input logic [23:0] o2
    );
        return {o2, o1, cb, y2, cr, y1};
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_idx idx, input logic [7:0] val);
        t_stim_row row;
        row = '{ROW_WRITE, idx, val, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_stim_row pair_row(input logic [InDataW-1:0] d, input bit known,
                                           input logic [OutDataW-1:0] rgb);
        t_stim_row row;
        row = '{ROW_PAIR, '0, '0, d, known, rgb};
        return row;
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAMMA_OFFSET: cfg_now.gamma_offset = val;
            CFG_BLUR_ENABLE:  cfg_now.blur_enable  = val[0];
            CFG_MONO_ENABLE:  cfg_now.mono_enable  = val[0];
            default: ;
        endcase
    endtask

    task automatic send_pair(input logic [InDataW-1:0] d, input bit known,
                             input logic [OutDataW-1:0] rgb);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        rgb_expect_q.push_back(known ? rgb : predict_rgb_pair(d, cfg_now));
    endtask

    // ---------------- receiver, checker, watchdog ----------------
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        logic [OutDataW-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_expect_q.size() == 0) begin
                $error("unexpected beat: rgb_first %h rgb_second %h",
                       m_axis_tdata[23:0], m_axis_tdata[47:24]);
                mismatch_count++;
            end else begin
                want = rgb_expect_q.pop_front();
                if (m_axis_tdata[23:0] !== want[23:0]) begin
                    $error("rgb_first: expected %h, got %h", want[23:0], m_axis_tdata[23:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[47:24] !== want[47:24]) begin
                    $error("rgb_second: expected %h, got %h",
                           want[47:24], m_axis_tdata[47:24]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        int seg, n;
        logic [7:0] gamma_pick;

        // reset state: gamma 0, colour, no blur
        stim_rows.push_back(pair_row(pack_pair(16, 128, 16, 128, 24'hffffff, 24'hffffff),
                                     1, {24'h000000, 24'h000000}));
        stim_rows.push_back(pair_row(pack_pair(255, 128, 255, 128, 24'h000000, 24'h000000),
                                     1, {24'hffffff, 24'hffffff}));
        stim_rows.push_back(pair_row(pack_pair(0, 128, 0, 128, 24'h5a5a5a, 24'ha5a5a5),
                                     1, {24'h000000, 24'h000000}));
        stim_rows.push_back(pair_row(pack_pair(0, 255, 255, 0, 24'h0, 24'h0), 0, '0));
        stim_rows.push_back(pair_row(pack_pair(255, 0, 0, 255, 24'h0, 24'h0), 0, '0));
        stim_rows.push_back(pair_row(pack_pair(128, 255, 128, 255, 24'h0, 24'h0), 0, '0));
        stim_rows.push_back(pair_row(pack_pair(128, 0, 128, 0, 24'h0, 24'h0), 0, '0));
        stim_rows.push_back(pair_row(pack_pair(235, 240, 16, 16, 24'h0, 24'h0), 0, '0));
        // grey mode
        stim_rows.push_back(reg_row(CFG_MONO_ENABLE, 8'd1));
        stim_rows.push_back(pair_row(pack_pair(0, 8'h5a, 255, 8'ha5, 24'h0, 24'h0),
                                     1, {24'hffffff, 24'h000000}));
        stim_rows.push_back(pair_row(pack_pair(8'h80, 0, 8'h7f, 255, 24'h0, 24'h0),
                                     1, {24'h7f7f7f, 24'h808080}));
        // gamma wrap
        stim_rows.push_back(reg_row(CFG_GAMMA_OFFSET, 8'd255));
        stim_rows.push_back(pair_row(pack_pair(0, 0, 1, 0, 24'h0, 24'h0),
                                     1, {24'h000000, 24'hffffff}));
        stim_rows.push_back(pair_row(pack_pair(8'h80, 0, 8'hff, 0, 24'h0, 24'h0),
                                     1, {24'hfefefe, 24'h7f7f7f}));
        // blur
        stim_rows.push_back(reg_row(CFG_BLUR_ENABLE, 8'd1));
        stim_rows.push_back(pair_row(pack_pair(1, 0, 0, 0, 24'hffffff, 24'h000000),
                                     1, {24'h7f7f7f, 24'h7f7f7f}));
        stim_rows.push_back(pair_row(pack_pair(0, 0, 1, 0, 24'hffffff, 24'h000000),
                                     1, {24'h000000, 24'hfefefe}));
        // colour with blur
        stim_rows.push_back(reg_row(CFG_MONO_ENABLE, 8'd0));
        stim_rows.push_back(reg_row(CFG_GAMMA_OFFSET, 8'd0));
        stim_rows.push_back(pair_row(pack_pair(255, 128, 16, 128, 24'h000000, 24'hffffff),
                                     1, {24'h7f7f7f, 24'h7f7f7f}));
        stim_rows.push_back(pair_row(pack_pair(200, 255, 50, 0, 24'h123456, 24'habcdef),
                                     0, '0));
        // unused index must not touch any register
        stim_rows.push_back(reg_row(CFG_SPARE, 8'hff));
        stim_rows.push_back(pair_row(pack_pair(16, 128, 16, 128, 24'h0, 24'h0),
                                     1, {24'h000000, 24'h000000}));
        // only bit 0 of the flag registers is kept
        stim_rows.push_back(reg_row(CFG_BLUR_ENABLE, 8'hfe));
        stim_rows.push_back(pair_row(pack_pair(255, 128, 255, 128, 24'h123456, 24'h123456),
                                     1, {24'hffffff, 24'hffffff}));
        stim_rows.push_back(reg_row(CFG_GAMMA_OFFSET, 8'd1));
        stim_rows.push_back(pair_row(pack_pair(15, 128, 254, 128, 24'h0, 24'h0),
                                     1, {24'hffffff, 24'h000000}));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_WRITE) begin
                write_reg(stim_rows[r].idx, stim_rows[r].val);
            end else begin
                send_pair(stim_rows[r].pair, stim_rows[r].known, stim_rows[r].rgb);
            end
        end

        for (seg = 0; seg < Segments; seg++) begin
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 84; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 84; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            case ($urandom_range(0, 3))
                0: gamma_pick = 8'd0;
                1: gamma_pick = 8'd255;
                default: gamma_pick = 8'($urandom);
            endcase
            write_reg(CFG_GAMMA_OFFSET, gamma_pick);
            write_reg(CFG_BLUR_ENABLE, 8'($urandom));
            write_reg(CFG_MONO_ENABLE, 8'($urandom));
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 8'($urandom));
            for (n = 0; n < SegItems; n++) begin
                send_pair(pack_pair(random_sample(), random_sample(), random_sample(),
                                    random_sample(), 24'($urandom), 24'($urandom)),
                          0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/yrb_pkg.sv
design/yrb_pixel.sv
design/yuyv_to_rgb_blend_unit.sv
design/yrb_checker.sv
test/tb.sv
